### src/ksbt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the key slot binding table.
// No dependencies.
package ksbt_pkg;

    localparam int KEY_W     = 32;
    localparam int SLOTS_DEF = 8;
    localparam int OUT_SLOT_W = 3;

    typedef logic [1:0]            t_opcode;
    typedef logic [2:0]            t_status;
    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [OUT_SLOT_W-1:0] t_out_slot;

    localparam t_opcode OP_BIND   = 2'd0;
    localparam t_opcode OP_UNBIND = 2'd1;
    localparam t_opcode OP_CLEAR  = 2'd2;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_RESERVED  = 3'd1;
    localparam t_status ST_BOUND     = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_NOT_BOUND = 3'd4;

    localparam t_key RESERVED_KEY_RST = 32'hFFFF_FFFF;

    typedef struct packed {
        logic load;
        logic match;
        logic resolve;
    } t_ctl_cmd;

endpackage

### src/ksbt_req_if.sv
`timescale 1ns / 1ps
// Request channel: opcode and key with valid/ready handshake.
// Depends on ksbt_pkg.
interface ksbt_req_if import ksbt_pkg::*; ();
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_key    key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

### src/ksbt_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: status and slot with valid/ready handshake.
// Depends on ksbt_pkg.
interface ksbt_rsp_if import ksbt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_status   status;
    t_out_slot slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

### src/ksbt_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one request through capture, match and resolve,
// and owns the handshakes. Depends on ksbt_pkg.
module ksbt_ctrl import ksbt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    output t_ctl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_MATCH   = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       can_load;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign can_load    = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.match   = 1'b0;
        o_cmd.resolve = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_RESOLVE;
            end
            S_RESOLVE: begin
                if (can_load) begin
                    o_cmd.resolve = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.resolve) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/ksbt_datapath.sv
`timescale 1ns / 1ps
// Datapath: slot key table, bound flags, reserved key, parallel key compare,
// priority encoders and the response register. Depends on ksbt_pkg.
module ksbt_datapath import ksbt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl_cmd  i_cmd,
    input  t_opcode   i_opcode,
    input  t_key      i_key,
    input  logic      i_cfg_we,
    input  t_key      i_cfg_wdata,
    output t_status   o_status,
    output t_out_slot o_slot
);

    localparam int SLOT_W = $clog2(SLOTS);

    t_key             r_rsv_key;
    t_opcode          r_op;
    t_key             r_key;
    t_key             r_slot_key [SLOTS];
    logic [SLOTS-1:0] r_slot_used;
    logic [SLOTS-1:0] r_hit_vec;
    logic             r_is_rsv;
    t_status          r_status;
    t_out_slot        r_slot;

    logic [SLOTS-1:0]    free_vec;
    logic                hit_any;
    logic                free_any;
    logic [SLOT_W-1:0]   hit_idx;
    logic [SLOT_W-1:0]   free_idx;
    logic [SLOT_W-1:0]   res_idx;
    logic [SLOT_W+2:0]   res_ext;
    t_status             res_status;
    logic                bind_we;
    logic                unbind_we;
    logic                clear_we;

    assign free_vec = ~r_slot_used;
    assign hit_any  = |r_hit_vec;
    assign free_any = |free_vec;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_hit_vec[i]) begin
                hit_idx = SLOT_W'(i);
            end
            if (free_vec[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        res_status = ST_OK;
        res_idx    = '0;
        bind_we    = 1'b0;
        unbind_we  = 1'b0;
        clear_we   = 1'b0;
        case (r_op)
            OP_BIND: begin
                if (r_is_rsv) begin
                    res_status = ST_RESERVED;
                end else if (hit_any) begin
                    res_status = ST_BOUND;
                end else if (!free_any) begin
                    res_status = ST_FULL;
                end else begin
                    res_idx = free_idx;
                    bind_we = 1'b1;
                end
            end
            OP_UNBIND: begin
                if (r_is_rsv) begin
                    res_status = ST_RESERVED;
                end else if (!hit_any) begin
                    res_status = ST_NOT_BOUND;
                end else begin
                    res_idx   = hit_idx;
                    unbind_we = 1'b1;
                end
            end
            OP_CLEAR: begin
                clear_we = 1'b1;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    assign res_ext = {3'b000, res_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsv_key <= RESERVED_KEY_RST;
        end else if (i_cfg_we) begin
            r_rsv_key <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_key <= i_key;
        end
        if (i_cmd.match) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_hit_vec[i] <= r_slot_used[i] && (r_slot_key[i] == r_key);
            end
            r_is_rsv <= (r_key == r_rsv_key);
        end
        if (i_cmd.resolve) begin
            r_status <= res_status;
            r_slot   <= res_ext[OUT_SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && bind_we) begin
            r_slot_key[free_idx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_used <= '0;
        end else if (i_cmd.resolve) begin
            if (clear_we) begin
                r_slot_used <= '0;
            end else if (bind_we) begin
                r_slot_used[free_idx] <= 1'b1;
            end else if (unbind_we) begin
                r_slot_used[hit_idx] <= 1'b0;
            end
        end
    end

    assign o_status = r_status;
    assign o_slot   = r_slot;

endmodule

### src/key_slot_binding_table.sv
`timescale 1ns / 1ps
// Key slot binding table: binds keys to the lowest free slot, unbinds, clears.
// A request passes capture, parallel compare and resolve, which registers the response
// and waits while an earlier response is not yet taken. Requests are taken one at a time.
// A waiting response does not block the next request's capture.
// Reset (synchronous, active low) frees all slots and sets the reserved key to all ones.
module key_slot_binding_table import ksbt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ksbt_req_if.sink   i_req,
    ksbt_rsp_if.source o_rsp,
    input  logic       i_cfg_we,
    input  t_key       i_cfg_wdata
);

    t_ctl_cmd cmd;

    ksbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    ksbt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_opcode    (i_req.opcode),
        .i_key       (i_req.key),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (o_rsp.status),
        .o_slot      (o_rsp.slot)
    );

endmodule

### src/ksbt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the key slot binding table, bound to the top level.
// Depends on ksbt_pkg and key_slot_binding_table.
module ksbt_checker import ksbt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_req_valid,
    input logic      i_req_ready,
    input logic      i_rsp_valid,
    input logic      i_rsp_ready,
    input t_status   i_rsp_status,
    input t_out_slot i_rsp_slot
);

    a_rsp_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while another is in work");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status <= ST_NOT_BOUND))
        else $error("undefined response status");

    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != ST_OK)) |-> (i_rsp_slot == '0))
        else $error("failed transaction reports a nonzero slot");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_slot)))
        else $error("stalled response changed");

endmodule

bind key_slot_binding_table ksbt_checker u_ksbt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_slot   (o_rsp.slot)
);
